FILE: hdl/imad_pkg.sv
package imad_pkg;

  // Block length limits, in chunks.
  localparam int MaxBlockChunks = 8192;
  localparam int MinBlockChunks = 2;
  localparam int LenW           = 14;
  localparam int PosW           = $clog2(MaxBlockChunks);

  // Reset value of the block length register.
  localparam logic [LenW-1:0] LenReset = LenW'(256);

  // Decoder arithmetic limits.
  localparam logic [6:0]         IdxMax    = 7'd88;
  localparam logic signed [17:0] SampleMax = 18'sd32767;
  localparam logic signed [17:0] SampleMin = -18'sd32768;
  localparam logic [3:0]         NibMask   = 4'hF;

  // Nibbles per channel word.
  localparam int NibPerWord = 8;
  localparam int CntW       = $clog2(NibPerWord);

  // Control that the sequencer sends to each lane.
  typedef struct packed {
    logic load;  // latch a new channel word
    logic hdr;   // the word being worked on is a header
    logic step;  // advance one decode step this cycle
  } lane_ctl_t;

  // Standard IMA step sizes.
  localparam logic [14:0] StepTable [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41,
    15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97,
    15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209,
    15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449,
    15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963,
    15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878,
    15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660,
    15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132,
    15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // Step size for an index; indexes above the table end use the last entry.
  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    logic [6:0] i;
    i = (idx > IdxMax) ? IdxMax : idx;
    return StepTable[i];
  endfunction

  // Index adjustment for a code; the sign bit of the code does not matter.
  function automatic logic signed [4:0] index_adjust(input logic [3:0] code);
    logic signed [4:0] adj;
    case (code[2:0])
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

FILE: hdl/imad_lane.sv
module imad_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  imad_pkg::lane_ctl_t     ctl,
  input  logic [31:0]             word_in,
  output logic signed [15:0]      sample
);

  logic [31:0]        word_r;
  logic signed [15:0] pred_r;
  logic signed [15:0] pred_nxt;
  logic [6:0]         idx_r;
  logic [6:0]         idx_nxt;

  logic [3:0]         nib;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [7:0]  ni;
  logic signed [15:0] dec_sample;
  logic [6:0]         hdr_idx;

  // One IMA decode step on the lowest nibble of the working word.
  always_comb begin
    nib  = word_r[3:0] & imad_pkg::NibMask;
    step = imad_pkg::step_lookup(idx_r);
    diff = {5'b0, step[14:3]};
    if (nib[2]) begin
      diff = diff + {2'b0, step};
    end
    if (nib[1]) begin
      diff = diff + {3'b0, step[14:1]};
    end
    if (nib[0]) begin
      diff = diff + {4'b0, step[14:2]};
    end
    if (nib[3]) begin
      sum = {{2{pred_r[15]}}, pred_r} - $signed({1'b0, diff});
    end else begin
      sum = {{2{pred_r[15]}}, pred_r} + $signed({1'b0, diff});
    end
    if (sum > imad_pkg::SampleMax) begin
      dec_sample = imad_pkg::SampleMax[15:0];
    end else if (sum < imad_pkg::SampleMin) begin
      dec_sample = imad_pkg::SampleMin[15:0];
    end else begin
      dec_sample = sum[15:0];
    end
    ni = $signed({1'b0, idx_r}) + 8'(imad_pkg::index_adjust(nib));
    if (ni < 8'sd0) begin
      idx_nxt = 7'd0;
    end else if (ni > $signed({1'b0, imad_pkg::IdxMax})) begin
      idx_nxt = imad_pkg::IdxMax;
    end else begin
      idx_nxt = ni[6:0];
    end
    pred_nxt = dec_sample;
  end

  // Header step index, clamped to the table end.
  assign hdr_idx = (word_r[23:16] > {1'b0, imad_pkg::IdxMax}) ? imad_pkg::IdxMax
                                                               : word_r[22:16];

  assign sample = ctl.hdr ? word_r[15:0] : dec_sample;

  // Channel state: predictor and step index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      idx_r  <= '0;
    end else if (ctl.step) begin
      if (ctl.hdr) begin
        pred_r <= word_r[15:0];
        idx_r  <= hdr_idx;
      end else begin
        pred_r <= pred_nxt;
        idx_r  <= idx_nxt;
      end
    end
  end

  // Working word: a new load wins over the nibble shift.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r <= word_in;
    end else if (ctl.step && !ctl.hdr) begin
      word_r <= {4'b0, word_r[31:4]};
    end
  end

endmodule

FILE: hdl/imad_merge.sv
module imad_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic               out_last_of_run
);

  logic               valid_r;
  logic               valid_nxt;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  logic               last_r;

  // The output register takes a new pair only when empty or being drained.
  always_comb begin
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Both lane samples join into one stereo result.
  always_ff @(posedge clk) begin
    if (push) begin
      left_r  <= left_in;
      right_r <= right_in;
      last_r  <= last_in;
    end
  end

  assign out_valid        = valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;
  assign out_last_of_run  = last_r;

endmodule

FILE: hdl/ima_adpcm_stereo_decoder_unit.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_left_word, in_right_word, in_new_stream
// out     | output    | out_valid/out_ready | out_left_sample, out_right_sample,
//         |           |                     | out_last_of_run
// cfg     | input     | cfg_wr_en           | cfg_wr_data (chunks_per_block)
//
// A header chunk takes one step and a data chunk eight: each channel lane decodes one
// nibble per cycle unless stalled, so the lanes' 8-step nibble iteration sets the rate.
// The next chunk is accepted in the cycle of the last step of the current one.
// Synchronous active-low reset clears the channel state, the block position and
// sets the block length to 256. A stall on the output holds the lanes in place.
module ima_adpcm_stereo_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_left_word,
  input  logic [31:0]        in_right_word,
  input  logic               in_new_stream,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic               out_last_of_run,
  input  logic               cfg_wr_en,
  input  logic [13:0]        cfg_wr_data
);

  localparam int LenW = imad_pkg::LenW;
  localparam int PosW = imad_pkg::PosW;
  localparam int CntW = imad_pkg::CntW;

  logic [LenW-1:0] cfg_len_r;
  logic [LenW-1:0] len;
  logic [PosW-1:0] pos_r;
  logic [PosW-1:0] pos_nxt;
  logic [PosW-1:0] pos_eff;
  logic [LenW:0]   pos_inc;
  logic            hdr_sel;

  logic            busy_r;
  logic            busy_nxt;
  logic            hdr_r;
  logic [CntW-1:0] cnt_r;
  logic            fire;
  logic            last_step;
  logic            in_acc;

  imad_pkg::lane_ctl_t lane_ctl;
  logic signed [15:0]  left_s;
  logic signed [15:0]  right_s;

  // Block length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= imad_pkg::LenReset;
    end else if (cfg_wr_en) begin
      cfg_len_r <= cfg_wr_data;
    end
  end

  // Effective block length, held within the supported range.
  always_comb begin
    if (cfg_len_r < LenW'(imad_pkg::MinBlockChunks)) begin
      len = LenW'(imad_pkg::MinBlockChunks);
    end else if (cfg_len_r > LenW'(imad_pkg::MaxBlockChunks)) begin
      len = LenW'(imad_pkg::MaxBlockChunks);
    end else begin
      len = cfg_len_r;
    end
  end

  // Sequencer handshake: a step fires when the output register can take a pair.
  assign fire      = busy_r && (!out_valid || out_ready);
  assign last_step = hdr_r || (cnt_r == CntW'(imad_pkg::NibPerWord - 1));
  assign in_ready  = !busy_r || (fire && last_step);
  assign in_acc    = in_valid && in_ready;

  // Block position: decide header or data when a chunk is accepted.
  always_comb begin
    if (in_new_stream || ({{(LenW-PosW){1'b0}}, pos_r} >= len)) begin
      pos_eff = '0;
    end else begin
      pos_eff = pos_r;
    end
    hdr_sel = (pos_eff == '0);
    pos_inc = {{(LenW-PosW+1){1'b0}}, pos_eff} + (LenW+1)'(1);
    if (pos_inc >= {1'b0, len}) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[PosW-1:0];
    end
  end

  always_comb begin
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (fire && last_step) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hdr_r  <= 1'b0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (in_acc) begin
        hdr_r <= hdr_sel;
        cnt_r <= '0;
        pos_r <= pos_nxt;
      end else if (fire) begin
        cnt_r <= cnt_r + CntW'(1);
      end
    end
  end

  assign lane_ctl.load = in_acc;
  assign lane_ctl.hdr  = hdr_r;
  assign lane_ctl.step = fire;

  // Two channel lanes decode side by side.
  imad_lane u_lane_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lane_ctl),
    .word_in (in_left_word),
    .sample  (left_s)
  );

  imad_lane u_lane_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lane_ctl),
    .word_in (in_right_word),
    .sample  (right_s)
  );

  // Merge the lane samples into one output transaction.
  imad_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (fire),
    .left_in          (left_s),
    .right_in         (right_s),
    .last_in          (last_step),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last_of_run  (out_last_of_run)
  );

  // An accepted chunk always keeps the sequencer busy in the next cycle.
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("sequencer not busy after accepting a chunk");

  // A data step before the eighth leaves the chunk still in progress.
  a_mid_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !last_step) |=> (busy_r && !in_ready) || (busy_r && fire && last_step))
    else $error("chunk ended before all eight pairs");

  // The final step of a chunk lands a flagged pair in the output register.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_step) |=> (out_valid && out_last_of_run))
    else $error("final pair of a chunk not flagged");

endmodule
